// File: rtl/core/pgpm_pkg.sv
// ----------------------------------------------------------------------------
// pgpm_pkg
// Shared widths, register map, command codes and inter-stage types of the
// page grid position mapper.
// ----------------------------------------------------------------------------
package pgpm_pkg;

  // field widths
  localparam int PAGE_BITS = 16;
  localparam int GRID_BITS = 12;
  localparam int CNT_BITS  = GRID_BITS + 1;

  // page plus offset, also the dividend and quotient width
  localparam int POS_BITS  = ((PAGE_BITS > CNT_BITS) ? PAGE_BITS : CNT_BITS) + 1;
  // count times cell index, then the sum and the doubled sum of cell to page
  localparam int PROD_BITS = CNT_BITS + CNT_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int CPOS_BITS = SUM_BITS + 1;

  // apb register file
  localparam int NUM_REGS  = 8;
  localparam int ADDR_BITS = $clog2(NUM_REGS * 4);
  localparam int DATA_BITS = 32;
  localparam int IDX_BITS  = ADDR_BITS - 2;

  typedef enum logic [IDX_BITS-1:0] {
    REG_ROW_COUNT      = 3'd0,
    REG_COLUMN_COUNT   = 3'd1,
    REG_PAGE_OFFSET    = 3'd2,
    REG_PAGE_COUNT     = 3'd3,
    REG_PAIRED_MODE    = 3'd4,
    REG_VERTICAL_ORDER = 3'd5,
    REG_RIGHT_TO_LEFT  = 3'd6,
    REG_BOTTOM_TO_TOP  = 3'd7
  } reg_idx_e;

  typedef enum logic {
    CMD_PAGE_TO_CELL = 1'b0,
    CMD_CELL_TO_PAGE = 1'b1
  } cmd_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [CNT_BITS-1:0]  row_count;
    logic [CNT_BITS-1:0]  column_count;
    logic [CNT_BITS-1:0]  page_offset;
    logic [PAGE_BITS-1:0] page_count;
    logic                 paired_mode;
    logic                 vertical_order;
    logic                 right_to_left;
    logic                 bottom_to_top;
  } cfg_t;

  // sideband that rides along the divider
  typedef struct packed {
    cmd_e                 cmd;
    logic                 inv;
    logic                 lsb;
    logic [PROD_BITS-1:0] prod;
    logic [CNT_BITS-1:0]  addend;
  } side_t;

endpackage

// File: rtl/core/pgpm_front.sv
// ----------------------------------------------------------------------------
// pgpm_front
// Request decode: range checks, mirroring, dividend and divisor selection,
// and the cell to page multiply. Two register stages.
// ----------------------------------------------------------------------------
module pgpm_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pgpm_pkg::cfg_t                   cfg_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  pgpm_pkg::cmd_e                   command_i,
  input  logic [pgpm_pkg::PAGE_BITS-1:0]   page_i,
  input  logic [pgpm_pkg::GRID_BITS-1:0]   column_i,
  input  logic [pgpm_pkg::GRID_BITS-1:0]   row_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [pgpm_pkg::POS_BITS-1:0]    dividend_o,
  output logic [pgpm_pkg::CNT_BITS-1:0]    divisor_o,
  output pgpm_pkg::side_t                  side_o
);
  import pgpm_pkg::*;

  logic                 en1, en2;
  logic [POS_BITS-1:0]  pos, slot;
  logic [CNT_BITS-1:0]  div, col_flip, row_flip;
  logic [CNT_BITS-1:0]  col_m, row_m;
  logic                 p2c_inv, c2p_inv;
  logic [CNT_BITS-1:0]  mul_a;
  logic [CNT_BITS-1:0]  mul_b, addend;
  logic                 lsb;

  logic                 vld1_q;
  cmd_e                 cmd1_q;
  logic                 inv1_q, lsb1_q;
  logic [POS_BITS-1:0]  slot1_q;
  logic [CNT_BITS-1:0]  div1_q, mula1_q;
  logic [CNT_BITS-1:0]  mulb1_q, add1_q;

  logic                 vld2_q;
  logic [POS_BITS-1:0]  dividend2_q;
  logic [CNT_BITS-1:0]  divisor2_q;
  side_t                side2_q;

  // stall chain, a stage moves when empty or when the next one moves
  assign en2     = !vld2_q || ready_i;
  assign en1     = !vld1_q || en2;
  assign ready_o = en1;

  // page to cell: position, slot (pairs share one slot) and divisor
  always_comb begin
    pos     = POS_BITS'(page_i) + POS_BITS'(cfg_i.page_offset);
    slot    = cfg_i.paired_mode ? (pos >> 1) : pos;
    if (cfg_i.vertical_order) begin
      div = cfg_i.row_count;
    end else begin
      div = cfg_i.paired_mode ? (cfg_i.column_count >> 1) : cfg_i.column_count;
    end
    p2c_inv = (page_i >= cfg_i.page_count) || (div == '0);
  end

  // cell to page: grid check, mirroring and multiply operands
  always_comb begin
    c2p_inv  = (CNT_BITS'(column_i) >= cfg_i.column_count) ||
               (CNT_BITS'(row_i) >= cfg_i.row_count);
    col_flip = cfg_i.column_count - CNT_BITS'(1) - CNT_BITS'(column_i);
    row_flip = cfg_i.row_count - CNT_BITS'(1) - CNT_BITS'(row_i);
    col_m    = cfg_i.right_to_left ? col_flip : CNT_BITS'(column_i);
    row_m    = cfg_i.bottom_to_top ? row_flip : CNT_BITS'(row_i);
    if (cfg_i.vertical_order) begin
      mul_a  = cfg_i.row_count;
      mul_b  = cfg_i.paired_mode ? (col_m >> 1) : col_m;
      addend = row_m;
    end else begin
      mul_a  = cfg_i.column_count;
      mul_b  = row_m;
      addend = col_m;
    end
    lsb = (command_i == CMD_PAGE_TO_CELL) ? pos[0] : col_m[0];
  end

  // stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en1) begin
      vld1_q <= valid_i;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      cmd1_q  <= command_i;
      inv1_q  <= (command_i == CMD_PAGE_TO_CELL) ? p2c_inv : c2p_inv;
      lsb1_q  <= lsb;
      slot1_q <= slot;
      div1_q  <= div;
      mula1_q <= mul_a;
      mulb1_q <= mul_b;
      add1_q  <= addend;
    end
  end

  // stage 2 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en2) begin
      vld2_q <= vld1_q;
    end
  end

  // stage 2 payload with the product
  always_ff @(posedge clk_i) begin
    if (en2 && vld1_q) begin
      dividend2_q    <= slot1_q;
      divisor2_q     <= div1_q;
      side2_q.cmd    <= cmd1_q;
      side2_q.inv    <= inv1_q;
      side2_q.lsb    <= lsb1_q;
      side2_q.prod   <= PROD_BITS'(mula1_q) * PROD_BITS'(mulb1_q);
      side2_q.addend <= add1_q;
    end
  end

  assign valid_o    = vld2_q;
  assign dividend_o = dividend2_q;
  assign divisor_o  = divisor2_q;
  assign side_o     = side2_q;

endmodule

// File: rtl/core/pgpm_div.sv
// ----------------------------------------------------------------------------
// pgpm_div
// Pipelined restoring divider, one quotient bit per stage, with the
// request sideband carried alongside.
// ----------------------------------------------------------------------------
module pgpm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [pgpm_pkg::POS_BITS-1:0]  dividend_i,
  input  logic [pgpm_pkg::CNT_BITS-1:0]  divisor_i,
  input  pgpm_pkg::side_t                side_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [pgpm_pkg::POS_BITS-1:0]  quo_o,
  output logic [pgpm_pkg::CNT_BITS-1:0]  rem_o,
  output pgpm_pkg::side_t                side_o
);
  import pgpm_pkg::*;

  localparam int NS = POS_BITS;

  logic                vld_q [NS];
  logic [CNT_BITS-1:0] rem_q [NS];
  logic [POS_BITS-1:0] quo_q [NS];
  logic [CNT_BITS-1:0] dvs_q [NS];
  side_t               side_q[NS];

  logic                en    [NS+1];
  logic                vld_s [NS];
  logic [CNT_BITS-1:0] rem_s [NS];
  logic [POS_BITS-1:0] quo_s [NS];
  logic [CNT_BITS-1:0] dvs_s [NS];
  side_t               side_s[NS];

  // stall chain from the output back to the input
  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end
  assign ready_o = en[0];

  // stage sources: stage 0 starts with an empty remainder
  always_comb begin
    vld_s[0]  = valid_i;
    rem_s[0]  = '0;
    quo_s[0]  = dividend_i;
    dvs_s[0]  = divisor_i;
    side_s[0] = side_i;
    for (int k = 1; k < NS; k++) begin
      vld_s[k]  = vld_q[k-1];
      rem_s[k]  = rem_q[k-1];
      quo_s[k]  = quo_q[k-1];
      dvs_s[k]  = dvs_q[k-1];
      side_s[k] = side_q[k-1];
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [CNT_BITS:0] trial, diff;
    logic              ge;

    // one trial subtract of the shifted remainder
    always_comb begin
      trial = {rem_s[g], quo_s[g][POS_BITS-1]};
      diff  = trial - {1'b0, dvs_s[g]};
      ge    = trial >= {1'b0, dvs_s[g]};
    end

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en[g]) begin
        vld_q[g] <= vld_s[g];
      end
    end

    // stage payload, quotient bits shift in from the right
    always_ff @(posedge clk_i) begin
      if (en[g] && vld_s[g]) begin
        rem_q[g]  <= ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
        quo_q[g]  <= {quo_s[g][POS_BITS-2:0], ge};
        dvs_q[g]  <= dvs_s[g];
        side_q[g] <= side_s[g];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign rem_o   = rem_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// File: rtl/core/pgpm_back.sv
// ----------------------------------------------------------------------------
// pgpm_back
// Result assembly: cell from quotient and remainder, page from the
// product, final range checks, mirroring and the output register.
// ----------------------------------------------------------------------------
module pgpm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pgpm_pkg::cfg_t                  cfg_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [pgpm_pkg::POS_BITS-1:0]   quo_i,
  input  logic [pgpm_pkg::CNT_BITS-1:0]   rem_i,
  input  pgpm_pkg::side_t                 side_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [pgpm_pkg::GRID_BITS-1:0]  column_o,
  output logic [pgpm_pkg::GRID_BITS-1:0]  row_o,
  output logic [pgpm_pkg::PAGE_BITS-1:0]  page_o,
  output logic                            result_valid_o
);
  import pgpm_pkg::*;

  localparam int CW = POS_BITS + 1;

  logic                 en1, en2;
  logic [POS_BITS-1:0]  col_raw, row_raw, rem_ext;
  logic [CW-1:0]        col_p;
  logic [SUM_BITS-1:0]  sum;
  logic [CPOS_BITS-1:0] cpos;

  logic                 vld1_q;
  cmd_e                 cmd1_q;
  logic                 inv1_q;
  logic [CW-1:0]        col1_q;
  logic [POS_BITS-1:0]  row1_q;
  logic [CPOS_BITS-1:0] cpos1_q;

  logic                 p2c_ok, c2p_ok;
  logic [CNT_BITS-1:0]  col_flip, row_flip;
  logic [GRID_BITS-1:0] col_fin, row_fin;
  logic [CPOS_BITS:0]   pdiff;

  logic                 vld2_q;
  logic [GRID_BITS-1:0] column_q, row_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 rv_q;

  // stall chain
  assign en2     = !vld2_q || ready_i;
  assign en1     = !vld1_q || en2;
  assign ready_o = en1;

  // cell from quotient and remainder, and the linear position of a cell
  always_comb begin
    rem_ext = POS_BITS'(rem_i);
    col_raw = cfg_i.vertical_order ? quo_i : rem_ext;
    row_raw = cfg_i.vertical_order ? rem_ext : quo_i;
    col_p   = cfg_i.paired_mode ? {col_raw, side_i.lsb} : {1'b0, col_raw};
    sum     = SUM_BITS'(side_i.prod) + SUM_BITS'(side_i.addend);
    cpos    = (cfg_i.vertical_order && cfg_i.paired_mode) ? {sum, side_i.lsb}
                                                           : {1'b0, sum};
  end

  // stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en1) begin
      vld1_q <= valid_i;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      cmd1_q  <= side_i.cmd;
      inv1_q  <= side_i.inv;
      col1_q  <= col_p;
      row1_q  <= row_raw;
      cpos1_q <= cpos;
    end
  end

  // final checks and mirroring
  always_comb begin
    p2c_ok   = !inv1_q && (col1_q < CW'(cfg_i.column_count)) &&
               (row1_q < POS_BITS'(cfg_i.row_count));
    col_flip = cfg_i.column_count - CNT_BITS'(1) - col1_q[CNT_BITS-1:0];
    row_flip = cfg_i.row_count - CNT_BITS'(1) - row1_q[CNT_BITS-1:0];
    col_fin  = cfg_i.right_to_left ? col_flip[GRID_BITS-1:0] : col1_q[GRID_BITS-1:0];
    row_fin  = cfg_i.bottom_to_top ? row_flip[GRID_BITS-1:0] : row1_q[GRID_BITS-1:0];
    pdiff    = {1'b0, cpos1_q} - (CPOS_BITS + 1)'(cfg_i.page_offset);
    c2p_ok   = !inv1_q && !pdiff[CPOS_BITS] &&
               (pdiff[CPOS_BITS-1:0] < CPOS_BITS'(cfg_i.page_count));
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en2) begin
      vld2_q <= vld1_q;
    end
  end

  // output register payload, unused fields read zero
  always_ff @(posedge clk_i) begin
    if (en2 && vld1_q) begin
      if (cmd1_q == CMD_PAGE_TO_CELL) begin
        column_q <= p2c_ok ? col_fin : '0;
        row_q    <= p2c_ok ? row_fin : '0;
        page_q   <= '0;
        rv_q     <= p2c_ok;
      end else begin
        column_q <= '0;
        row_q    <= '0;
        page_q   <= c2p_ok ? pdiff[PAGE_BITS-1:0] : '0;
        rv_q     <= c2p_ok;
      end
    end
  end

  assign valid_o        = vld2_q;
  assign column_o       = column_q;
  assign row_o          = row_q;
  assign page_o         = page_q;
  assign result_valid_o = rv_q;

endmodule

// File: rtl/core/page_grid_position_mapper_top.sv
// ----------------------------------------------------------------------------
// page_grid_position_mapper_top
// Page index to grid cell mapper and its inverse, with an APB register file.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the pipeline is not stalled
// and returns one result per request, in order. Every request passes the same
// pipeline: two decode stages (range checks, mirroring, cell to page multiply),
// one divider stage per quotient bit (17 stages for a 17-bit page plus offset)
// and two result stages. A stall at the output only stops the stages that are
// full, so empty stages keep taking requests. Registers are written over APB at
// byte address 4*index and must only change while no request is in flight.
module page_grid_position_mapper_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pgpm_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [pgpm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [pgpm_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [pgpm_pkg::PAGE_BITS-1:0]  page_in_i,
  input  logic [pgpm_pkg::GRID_BITS-1:0]  column_in_i,
  input  logic [pgpm_pkg::GRID_BITS-1:0]  row_in_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pgpm_pkg::GRID_BITS-1:0]  column_out_o,
  output logic [pgpm_pkg::GRID_BITS-1:0]  row_out_o,
  output logic [pgpm_pkg::PAGE_BITS-1:0]  page_out_o,
  output logic                            result_valid_o
);
  import pgpm_pkg::*;

  cfg_t                 cfg_q;
  reg_idx_e             reg_idx;
  logic                 wr_en;

  logic                 fr_valid, fr_ready;
  logic [POS_BITS-1:0]  fr_dividend;
  logic [CNT_BITS-1:0]  fr_divisor;
  side_t                fr_side;

  logic                 dv_valid, dv_ready;
  logic [POS_BITS-1:0]  dv_quo;
  logic [CNT_BITS-1:0]  dv_rem;
  side_t                dv_side;

  // register write on the apb access phase
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_BITS-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count      <= CNT_BITS'(1);
      cfg_q.column_count   <= CNT_BITS'(1);
      cfg_q.page_offset    <= '0;
      cfg_q.page_count     <= '0;
      cfg_q.paired_mode    <= 1'b0;
      cfg_q.vertical_order <= 1'b1;
      cfg_q.right_to_left  <= 1'b0;
      cfg_q.bottom_to_top  <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROW_COUNT:      cfg_q.row_count      <= pwdata[CNT_BITS-1:0];
        REG_COLUMN_COUNT:   cfg_q.column_count   <= pwdata[CNT_BITS-1:0];
        REG_PAGE_OFFSET:    cfg_q.page_offset    <= pwdata[CNT_BITS-1:0];
        REG_PAGE_COUNT:     cfg_q.page_count     <= pwdata[PAGE_BITS-1:0];
        REG_PAIRED_MODE:    cfg_q.paired_mode    <= pwdata[0];
        REG_VERTICAL_ORDER: cfg_q.vertical_order <= pwdata[0];
        REG_RIGHT_TO_LEFT:  cfg_q.right_to_left  <= pwdata[0];
        REG_BOTTOM_TO_TOP:  cfg_q.bottom_to_top  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_ROW_COUNT:      prdata = DATA_BITS'(cfg_q.row_count);
      REG_COLUMN_COUNT:   prdata = DATA_BITS'(cfg_q.column_count);
      REG_PAGE_OFFSET:    prdata = DATA_BITS'(cfg_q.page_offset);
      REG_PAGE_COUNT:     prdata = DATA_BITS'(cfg_q.page_count);
      REG_PAIRED_MODE:    prdata = DATA_BITS'(cfg_q.paired_mode);
      REG_VERTICAL_ORDER: prdata = DATA_BITS'(cfg_q.vertical_order);
      REG_RIGHT_TO_LEFT:  prdata = DATA_BITS'(cfg_q.right_to_left);
      REG_BOTTOM_TO_TOP:  prdata = DATA_BITS'(cfg_q.bottom_to_top);
      default:            prdata = '0;
    endcase
  end

  // decode and multiply
  pgpm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .command_i  (cmd_e'(command_i)),
    .page_i     (page_in_i),
    .column_i   (column_in_i),
    .row_i      (row_in_i),
    .valid_o    (fr_valid),
    .ready_i    (fr_ready),
    .dividend_o (fr_dividend),
    .divisor_o  (fr_divisor),
    .side_o     (fr_side)
  );

  // divider pipeline
  pgpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (fr_valid),
    .ready_o    (fr_ready),
    .dividend_i (fr_dividend),
    .divisor_i  (fr_divisor),
    .side_i     (fr_side),
    .valid_o    (dv_valid),
    .ready_i    (dv_ready),
    .quo_o      (dv_quo),
    .rem_o      (dv_rem),
    .side_o     (dv_side)
  );

  // result assembly and output register
  pgpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .valid_i        (dv_valid),
    .ready_o        (dv_ready),
    .quo_i          (dv_quo),
    .rem_i          (dv_rem),
    .side_i         (dv_side),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .column_o       (column_out_o),
    .row_o          (row_out_o),
    .page_o         (page_out_o),
    .result_valid_o (result_valid_o)
  );

`ifndef NO_ASSERTIONS
  // an invalid result carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_valid_o |->
      column_out_o == '0 && row_out_o == '0 && page_out_o == '0)
    else $error("invalid result with nonzero fields");

  // a valid result always names a cell inside the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_valid_o |->
      CNT_BITS'(column_out_o) < cfg_q.column_count &&
      CNT_BITS'(row_out_o) < cfg_q.row_count)
    else $error("valid result outside the grid");

  // a valid result always names an existing page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_valid_o |-> page_out_o < cfg_q.page_count)
    else $error("valid result beyond the page count");

  // the input only stalls when the output is blocked and the front, divider and output stages hold data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && fr_valid && dv_valid)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
